// ===== rtl/core/gqg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_pkg: glyph quad generator shared types
// Payload structs, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package gqg_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X    = 3'd0,
		REG_START_Y    = 3'd1,
		REG_START_Z    = 3'd2,
		REG_SCALE_X    = 3'd3,
		REG_SCALE_Y    = 3'd4,
		REG_SPACING    = 3'd5,
		REG_UV_SCALE_X = 3'd6,
		REG_UV_SCALE_Y = 3'd7
	} cfg_reg_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  char_code;
		logic        first_of_string;
		logic [11:0] atlas_x;
		logic [11:0] atlas_y;
		logic [11:0] atlas_w;
		logic [11:0] atlas_h;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic [1:0]         corner;
		logic               last_corner;
	} out_item_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/core/gqg_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_divider: restoring radix-2 divider
// Unsigned 44 by 12 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gqg_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  gqg_pkg::div_ctl_t ctl,
	input  logic [43:0]       dividend,
	input  logic [11:0]       divisor,
	output gqg_pkg::div_sts_t sts,
	output logic [31:0]       quotient
);

	logic [43:0] quo_q;
	logic [12:0] rem_q;
	logic [11:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [12:0] trial;

	assign trial = {rem_q[11:0], quo_q[43]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd44;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			// shift in one dividend bit, subtract when it fits
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[42:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[42:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q[31:0];

endmodule

// ===== rtl/core/glyph_quad_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_generator_unit: bitmap font glyph quad layout
// Looks up atlas rectangles and emits four textured quad corners per glyph.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_item): a load transaction writes one
//   glyph table entry; a draw transaction emits four corner transactions on
//   the out channel (out_valid/out_stall/out_item), bottom-left first.
//   Configuration writes (cfg_we/cfg_idx/cfg_data) are to be made only while
//   the unit is idle; the unit itself does not enforce this.
// Draw sequence:
//   A load, or a draw that emits nothing, leaves the unit idle and ready for
//   the next transaction. A draw of a printable code does one table read,
//   forms scale_x*w, divides it by the glyph height in a radix-2 divider that
//   retires one quotient bit per cycle over 44 bits, and then runs four
//   multiplies one at a time through a single 32x25 multiplier. A zero glyph
//   height skips the divider. Corners then leave one per cycle while out_stall
//   is low, and the next transaction is taken once the last corner is out.
// Reset:
//   Configuration registers return to their reset values, pen and count
//   clear, and the 95-entry table reads as zero through per-entry valid bits.
// Stall:
//   A stalled corner holds on the out port; the unit does not take a new
//   in transaction until the last corner has been taken.
// ----------------------------------------------------------------------------
module glyph_quad_generator_unit #(
	parameter int unsigned GLYPH_COUNT           = 95,
	parameter int unsigned FIRST_CODE            = 32,
	parameter int unsigned MAX_GLYPHS_PER_STRING = 4096,
	parameter int unsigned ATLAS_COORD_BITS      = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gqg_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gqg_pkg::out_item_t                  out_item,
	input  logic                                cfg_we,
	input  logic [gqg_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [gqg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_GLYPHS_PER_STRING + 1);
	localparam logic [11:0] ATLAS_MASK = 12'((13'd1 << ATLAS_COORD_BITS) - 13'd1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOK, ST_DIV, ST_MU0, ST_MU1, ST_MV0, ST_MV1, ST_EMIT
	} state_t;

	// configuration registers
	logic [31:0] start_x_q, start_y_q, start_z_q, scale_x_q, scale_y_q, spacing_q;
	logic [24:0] uv_scale_x_q, uv_scale_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= '0;
			start_y_q    <= '0;
			start_z_q    <= '0;
			scale_x_q    <= 32'd65536;
			scale_y_q    <= 32'd65536;
			spacing_q    <= '0;
			uv_scale_x_q <= 25'd65536;
			uv_scale_y_q <= 25'd65536;
		end else if (cfg_we) begin
			unique case (gqg_pkg::cfg_reg_t'(cfg_idx))
				gqg_pkg::REG_START_X:    start_x_q    <= cfg_data;
				gqg_pkg::REG_START_Y:    start_y_q    <= cfg_data;
				gqg_pkg::REG_START_Z:    start_z_q    <= cfg_data;
				gqg_pkg::REG_SCALE_X:    scale_x_q    <= cfg_data;
				gqg_pkg::REG_SCALE_Y:    scale_y_q    <= cfg_data;
				gqg_pkg::REG_SPACING:    spacing_q    <= cfg_data;
				gqg_pkg::REG_UV_SCALE_X: uv_scale_x_q <= cfg_data[24:0];
				gqg_pkg::REG_UV_SCALE_Y: uv_scale_y_q <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	// glyph table memory, one 48-bit row per printable code
	logic [47:0]            table_mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] entry_vld_q;
	logic [47:0]            rd_data_q;
	logic                   rd_vld_q;

	// printable check on the incoming code
	logic [8:0]       code_off;
	logic             code_ok;
	logic [IDX_W-1:0] code_idx;

	assign code_off = {1'b0, in_item.char_code} - 9'(FIRST_CODE);
	assign code_ok  = ({1'b0, in_item.char_code} >= 9'(FIRST_CODE)) &&
	                  (code_off < 9'(GLYPH_COUNT));
	assign code_idx = code_off[IDX_W-1:0];

	state_t                  state_q;
	logic                    accept;
	logic [IDX_W-1:0]        idx_q;
	logic                    draw_ok_q;
	logic [31:0]             pen_x_q;
	logic [CNT_W-1:0]        count_q;
	logic [31:0]             width_q;
	logic [31:0]             u0_q, du_q, v0_q, dv_q;
	logic [1:0]              corner_q;
	logic                    out_valid_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept && in_item.cmd == gqg_pkg::CMD_LOAD && code_ok)
			table_mem[code_idx] <= {in_item.atlas_x & ATLAS_MASK,
			                        in_item.atlas_y & ATLAS_MASK,
			                        in_item.atlas_w & ATLAS_MASK,
			                        in_item.atlas_h & ATLAS_MASK};
		if (state_q == ST_LOOK)
			rd_data_q <= table_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (accept && in_item.cmd == gqg_pkg::CMD_LOAD && code_ok)
				entry_vld_q[code_idx] <= 1'b1;
			if (state_q == ST_LOOK)
				rd_vld_q <= entry_vld_q[idx_q];
		end
	end

	// unpacked entry, zero when never loaded
	logic [11:0] gx, gy, gw, gh;
	assign {gx, gy, gw, gh} = rd_vld_q ? rd_data_q : 48'd0;

	// shared multiplier: 32 x 25 unsigned, registered product
	logic [31:0] mul_a;
	logic [24:0] mul_b;
	logic [56:0] prod_q;

	always_comb begin
		mul_a = {20'd0, gw};
		mul_b = {13'd0, 12'd0};
		unique case (state_q)
			ST_LOOK: begin mul_a = scale_x_q; mul_b = 25'd0; end
			ST_DIV:  begin mul_a = scale_x_q; mul_b = {13'd0, gw}; end
			ST_MU0:  begin mul_a = {19'd0, gx, 1'b0} - 32'd1; mul_b = uv_scale_x_q; end
			ST_MU1:  begin mul_a = {20'd0, gw} + 32'd1; mul_b = uv_scale_x_q; end
			ST_MV0:  begin mul_a = {19'd0, gy, 1'b0} - 32'd1; mul_b = uv_scale_y_q; end
			ST_MV1:  begin mul_a = {20'd0, gh} + 32'd1; mul_b = uv_scale_y_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 57'(mul_a) * 57'(mul_b);
	end

	// (2x-1)*s/2 floored; only x == 0 yields the negative product -s
	function automatic logic [31:0] tex_org(input logic [11:0] c, input logic [56:0] p,
	                                        input logic [24:0] s);
		logic [25:0] neg;
		begin
			neg = ({1'b0, s} + 26'd1) >> 1;
			if (c == 12'd0)
				tex_org = 32'd0 - 32'(neg);
			else
				tex_org = p[32:1];
		end
	endfunction

	// divider
	gqg_pkg::div_ctl_t div_ctl;
	gqg_pkg::div_sts_t div_sts;
	logic [31:0]       div_quo;
	logic              div_started_q;
	logic              prod_valid_q;

	assign div_ctl.start = (state_q == ST_DIV) && !div_started_q && !div_sts.busy &&
	                       (gh != 12'd0) && prod_valid_q;

	gqg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q[43:0]),
		.divisor  (gh),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pen_x_q       <= '0;
			count_q       <= '0;
			corner_q      <= '0;
			out_valid_q   <= 1'b0;
			draw_ok_q     <= 1'b0;
			div_started_q <= 1'b0;
			prod_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.cmd == gqg_pkg::CMD_DRAW) begin
							logic [CNT_W-1:0] cnt;
							cnt = in_item.first_of_string ? '0 : count_q;
							if (in_item.first_of_string) begin
								pen_x_q <= start_x_q;
								count_q <= '0;
							end
							idx_q <= code_idx;
							if (code_ok && cnt < CNT_W'(MAX_GLYPHS_PER_STRING))
								state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					div_started_q <= 1'b0;
					prod_valid_q  <= 1'b0;
					state_q       <= ST_DIV;
				end
				ST_DIV: begin
					// form scale_x*w first, then run the divider unless the height is zero
					prod_valid_q <= 1'b1;
					if (prod_valid_q) begin
						if (gh == 12'd0) begin
							width_q <= '0;
							state_q <= ST_MU0;
						end else if (div_ctl.start) begin
							div_started_q <= 1'b1;
						end else if (div_sts.done) begin
							width_q <= div_quo;
							state_q <= ST_MU0;
						end
					end
				end
				ST_MU0: state_q <= ST_MU1;
				ST_MU1: begin
					u0_q    <= tex_org(gx, prod_q, uv_scale_x_q);
					state_q <= ST_MV0;
				end
				ST_MV0: begin
					du_q    <= prod_q[31:0];
					state_q <= ST_MV1;
				end
				ST_MV1: begin
					v0_q        <= tex_org(gy, prod_q, uv_scale_y_q);
					state_q     <= ST_EMIT;
					corner_q    <= '0;
					out_valid_q <= 1'b0;
					draw_ok_q   <= 1'b1;
				end
				ST_EMIT: begin
					if (draw_ok_q) begin
						dv_q        <= prod_q[31:0];
						draw_ok_q   <= 1'b0;
						out_valid_q <= 1'b1;
					end else if (!out_stall) begin
						if (corner_q == 2'd3) begin
							out_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
							pen_x_q     <= pen_x_q + width_q + spacing_q;
							count_q     <= count_q + CNT_W'(1);
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// corner assembly
	logic [31:0] x1, z1, u1, v1;
	assign x1 = pen_x_q + width_q;
	assign z1 = start_z_q + scale_y_q;
	assign u1 = u0_q + du_q;
	assign v1 = v0_q + dv_q;

	assign out_valid = out_valid_q;

	always_comb begin
		out_item.pos_y       = start_y_q;
		out_item.corner      = corner_q;
		out_item.last_corner = (corner_q == 2'd3);
		out_item.pos_x       = (corner_q == 2'd1 || corner_q == 2'd2) ? x1 : pen_x_q;
		out_item.tex_u       = (corner_q == 2'd1 || corner_q == 2'd2) ? u1 : u0_q;
		out_item.pos_z       = corner_q[1] ? z1 : start_z_q;
		out_item.tex_v       = corner_q[1] ? v1 : v0_q;
	end

endmodule

// ===== rtl/core/gqg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqg_checker: port-level checks for the glyph quad generator
// Watches corner order and input blocking during output.
// ----------------------------------------------------------------------------
module gqg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input gqg_pkg::out_item_t out_item
);

	// no input transaction is taken while corners are pending
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");

	// last_corner marks corner 3 only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.last_corner == (out_item.corner == 2'd3)))
		else $error("last_corner mismatch");

	// a taken non-final corner is followed by the next corner
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_item.last_corner) |=>
		(out_valid && out_item.corner == $past(out_item.corner) + 2'd1))
		else $error("corner sequence broken");

	// holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled output changed");

endmodule

bind glyph_quad_generator_unit gqg_checker u_gqg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== bench/tb_glyph_quad_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_quad_generator_unit: self-checking bench for the glyph quad unit
// Drives load and draw transactions with random idle bursts on both channels.
// A scoreboard class predicts the four corners of every drawn glyph and
// checks each out transaction against the oldest pending corner.
// ----------------------------------------------------------------------------

class corner_tracker;
	localparam int NUM_GLYPHS = 95;
	localparam int BASE_CODE  = 32;
	localparam int STRING_CAP = 4096;

	logic [11:0] gx [NUM_GLYPHS];
	logic [11:0] gy [NUM_GLYPHS];
	logic [11:0] gw [NUM_GLYPHS];
	logic [11:0] gh [NUM_GLYPHS];
	logic [31:0] regs [8];
	logic [31:0] pen;
	int unsigned drawn;
	gqg_pkg::out_item_t pending_corners [$];
	int unsigned errors;

	function new();
		for (int i = 0; i < NUM_GLYPHS; i++) begin
			gx[i] = '0; gy[i] = '0; gw[i] = '0; gh[i] = '0;
		end
		foreach (regs[i]) regs[i] = '0;
		regs[gqg_pkg::REG_SCALE_X]    = 32'd65536;
		regs[gqg_pkg::REG_SCALE_Y]    = 32'd65536;
		regs[gqg_pkg::REG_UV_SCALE_X] = 32'd65536;
		regs[gqg_pkg::REG_UV_SCALE_Y] = 32'd65536;
		pen    = '0;
		drawn  = 0;
		errors = 0;
	endfunction

	function void set_reg(gqg_pkg::cfg_reg_t r, logic [31:0] v);
		if (r == gqg_pkg::REG_UV_SCALE_X || r == gqg_pkg::REG_UV_SCALE_Y)
			regs[r] = v & 32'h01FF_FFFF;
		else
			regs[r] = v;
	endfunction

	// floor((2c-1)*s/2), wrapped to 32 bits
	function logic [31:0] tex_origin(logic [11:0] c, logic [31:0] s);
		longint p;
		longint r;
		p = (longint'(c) * 2 - 1) * longint'(s);
		r = p >>> 1;
		return r[31:0];
	endfunction

	function void note_item(gqg_pkg::in_item_t it);
		int idx;
		logic [63:0] wq;
		logic [63:0] tmp;
		logic [31:0] w32, x0, x1, z0, z1, u0, u1, v0, v1;
		gqg_pkg::out_item_t c;
		idx = int'(it.char_code) - BASE_CODE;
		if (it.cmd == gqg_pkg::CMD_LOAD) begin
			if (idx >= 0 && idx < NUM_GLYPHS) begin
				gx[idx] = it.atlas_x; gy[idx] = it.atlas_y;
				gw[idx] = it.atlas_w; gh[idx] = it.atlas_h;
			end
			return;
		end
		if (it.first_of_string) begin
			pen   = regs[gqg_pkg::REG_START_X];
			drawn = 0;
		end
		if (idx < 0 || idx >= NUM_GLYPHS) return;
		if (drawn >= STRING_CAP) return;
		// zero glyph height gives a zero-width quad
		wq = '0;
		if (gh[idx] != 0)
			wq = ({32'b0, regs[gqg_pkg::REG_SCALE_X]} * {52'b0, gw[idx]}) /
			     {52'b0, gh[idx]};
		w32 = wq[31:0];
		x0 = pen;
		x1 = x0 + w32;
		z0 = regs[gqg_pkg::REG_START_Z];
		z1 = z0 + regs[gqg_pkg::REG_SCALE_Y];
		u0 = tex_origin(gx[idx], regs[gqg_pkg::REG_UV_SCALE_X]);
		v0 = tex_origin(gy[idx], regs[gqg_pkg::REG_UV_SCALE_Y]);
		tmp = {52'b0, gw[idx]} + 64'd1;
		tmp = tmp * {32'b0, regs[gqg_pkg::REG_UV_SCALE_X]};
		u1 = u0 + tmp[31:0];
		tmp = {52'b0, gh[idx]} + 64'd1;
		tmp = tmp * {32'b0, regs[gqg_pkg::REG_UV_SCALE_Y]};
		v1 = v0 + tmp[31:0];
		for (int k = 0; k < 4; k++) begin
			c.pos_x       = (k == 0 || k == 3) ? x0 : x1;
			c.pos_y       = regs[gqg_pkg::REG_START_Y];
			c.pos_z       = (k < 2) ? z0 : z1;
			c.tex_u       = (k == 0 || k == 3) ? u0 : u1;
			c.tex_v       = (k < 2) ? v0 : v1;
			c.corner      = k[1:0];
			c.last_corner = (k == 3);
			pending_corners.push_back(c);
		end
		pen = pen + w32 + regs[gqg_pkg::REG_SPACING];
		drawn++;
	endfunction

	function void check_corner(gqg_pkg::out_item_t got);
		gqg_pkg::out_item_t want;
		if (pending_corners.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected corner transaction: %h", got);
			return;
		end
		want = pending_corners.pop_front();
		if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
			got.pos_z !== want.pos_z || got.tex_u !== want.tex_u ||
			got.tex_v !== want.tex_v || got.corner !== want.corner ||
			got.last_corner !== want.last_corner) begin
			errors++;
			if (errors <= 10)
				$display("corner mismatch: expected %h actual %h", want, got);
		end
	endfunction
endclass

module tb_glyph_quad_generator_unit;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	gqg_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	gqg_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [gqg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [gqg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	corner_tracker tracker = new();
	// drop all idling near the end of the run
	bit quiet = 1'b0;
	int stall_left = 0;
	int idle_cycles = 0;

	glyph_quad_generator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Check every corner the unit hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_corner(out_item);
	end

	// Stall the out channel in random bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// End the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Present one transaction, hold it until taken, then return on a falling edge.
	task automatic send(gqg_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		tracker.note_item(it);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic load_glyph(logic [7:0] code, logic [11:0] ax, logic [11:0] ay,
		logic [11:0] aw, logic [11:0] ah);
		gqg_pkg::in_item_t it;
		it.cmd = gqg_pkg::CMD_LOAD; it.char_code = code;
		it.first_of_string = 1'($urandom_range(0, 1));
		it.atlas_x = ax; it.atlas_y = ay; it.atlas_w = aw; it.atlas_h = ah;
		send(it);
	endtask

	task automatic draw_char(logic [7:0] code, logic first);
		gqg_pkg::in_item_t it;
		it.cmd = gqg_pkg::CMD_DRAW; it.char_code = code; it.first_of_string = first;
		it.atlas_x = 12'($urandom); it.atlas_y = 12'($urandom);
		it.atlas_w = 12'($urandom); it.atlas_h = 12'($urandom);
		send(it);
	endtask

	// Hold off until every pending corner is out, then let the unit go idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_corners.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(gqg_pkg::cfg_reg_t r, logic [31:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= v;
		tracker.set_reg(r, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		write_reg(gqg_pkg::REG_START_X, $urandom);
		write_reg(gqg_pkg::REG_START_Y, $urandom);
		write_reg(gqg_pkg::REG_START_Z, $urandom);
		write_reg(gqg_pkg::REG_SCALE_X, $urandom);
		write_reg(gqg_pkg::REG_SCALE_Y, $urandom);
		write_reg(gqg_pkg::REG_SPACING, $urandom);
		write_reg(gqg_pkg::REG_UV_SCALE_X, $urandom_range(0, 16777216));
		write_reg(gqg_pkg::REG_UV_SCALE_Y, $urandom_range(0, 16777216));
	endtask

	// Mostly printable codes; now and then any code at all.
	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset registers, never-loaded entry, table edges, odd codes.
		draw_char(8'd65, 1'b1);
		load_glyph(8'd32, 12'd0, 12'd0, 12'd0, 12'd0);
		load_glyph(8'd126, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		load_glyph(8'd31, 12'd5, 12'd5, 12'd5, 12'd5);
		load_glyph(8'd127, 12'd7, 12'd7, 12'd7, 12'd7);
		load_glyph(8'd0, 12'd9, 12'd9, 12'd9, 12'd9);
		load_glyph(8'd255, 12'd9, 12'd9, 12'd9, 12'd9);
		load_glyph(8'd72, 12'd10, 12'd20, 12'd8, 12'd0);
		draw_char(8'd32, 1'b1);
		draw_char(8'd126, 1'b0);
		draw_char(8'd72, 1'b0);
		draw_char(8'd31, 1'b0);
		draw_char(8'd127, 1'b1);
		draw_char(8'd126, 1'b0);
		draw_char(8'd255, 1'b0);
		draw_char(8'd0, 1'b0);
		settle();

		// Directed: register extremes.
		write_reg(gqg_pkg::REG_START_X, 32'h7FFF_FFFF);
		write_reg(gqg_pkg::REG_START_Y, 32'h8000_0000);
		write_reg(gqg_pkg::REG_START_Z, 32'h7FFF_FFFF);
		write_reg(gqg_pkg::REG_SCALE_X, 32'hFFFF_FFFF);
		write_reg(gqg_pkg::REG_SCALE_Y, 32'hFFFF_FFFF);
		write_reg(gqg_pkg::REG_SPACING, 32'h8000_0000);
		write_reg(gqg_pkg::REG_UV_SCALE_X, 32'd16777216);
		write_reg(gqg_pkg::REG_UV_SCALE_Y, 32'd16777216);
		draw_char(8'd126, 1'b1);
		draw_char(8'd126, 1'b0);
		draw_char(8'd32, 1'b0);
		load_glyph(8'd33, 12'd1, 12'hFFF, 12'd1, 12'hFFF);
		draw_char(8'd33, 1'b0);
		settle();
		write_reg(gqg_pkg::REG_SCALE_X, 32'd0);
		write_reg(gqg_pkg::REG_SCALE_Y, 32'd0);
		write_reg(gqg_pkg::REG_UV_SCALE_X, 32'd0);
		write_reg(gqg_pkg::REG_UV_SCALE_Y, 32'd0);
		write_reg(gqg_pkg::REG_START_X, 32'h8000_0000);
		draw_char(8'd126, 1'b1);
		draw_char(8'd33, 1'b0);
		settle();

		// Random phases, each under a fresh register setting.
		for (int phase = 0; phase < 4; phase++) begin
			random_config();
			for (int n = 0; n < 40; n++) begin
				if ($urandom_range(0, 2) == 0)
					load_glyph(pick_code(), 12'($urandom), 12'($urandom), 12'($urandom),
						($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom));
				else
					draw_char(pick_code(), $urandom_range(0, 7) == 0);
				// hold the sender once until all corners are out
				if (phase == 1 && n == 27)
					while (tracker.pending_corners.size() != 0) @(negedge clk);
			end
			settle();
		end

		// One longer string, then restart the string.
		random_config();
		write_reg(gqg_pkg::REG_UV_SCALE_X, 32'd16777216);
		load_glyph(8'd66, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
		quiet = 1'b1;
		draw_char(8'd66, 1'b1);
		for (int n = 0; n < 10; n++)
			draw_char(8'd66, 1'b0);
		draw_char(8'd66, 1'b1);
		draw_char(8'd66, 1'b0);

		// Final stretch with no idling at all.
		for (int n = 0; n < 20; n++)
			draw_char(pick_code(), 1'b0);

		in_valid <= 1'b0;
		while (tracker.pending_corners.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.pending_corners.size() != 0)
			tracker.errors++;
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
